// ----- sv/nearest_downscale_rgba5551_core_assert.svh -----
// assertion macros shared by the downscaler rtl
`ifndef NEAREST_DOWNSCALE_RGBA5551_CORE_ASSERT_SVH
`define NEAREST_DOWNSCALE_RGBA5551_CORE_ASSERT_SVH

// same-cycle implication, held off during reset
`define NDS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define NDS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/nds_pkg.sv -----
// types and constants shared by the downscaler modules
package nds_pkg;

    localparam int DIM_W     = 13;
    localparam int COORD_W   = 12;
    localparam int SAMPLE_W  = 8;
    localparam int PIX_W     = 16;
    localparam int CC_W      = 3;
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W    = 2 * DIM_W;

    // largest source and box side, sizes saturate here
    localparam int MAX_DIM   = 4096;

    // pixel packing
    localparam int RED_LSB   = 11;
    localparam int GREEN_LSB = 6;
    localparam int BLUE_LSB  = 1;
    localparam int DROP_BITS = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_WIDTH       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_HEIGHT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COMPONENT_COUNT = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIT_A,
        S_FIT_B,
        S_FIT_CHOOSE,
        S_FIT_WAIT,
        S_ROW,
        S_ROW_WAIT,
        S_PICK,
        S_PICK_START,
        S_PICK_WAIT,
        S_FINISH
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_FIT_MUL_A,
        OP_FIT_MUL_B,
        OP_FIT_KEEP,
        OP_FIT_START,
        OP_FIT_SET,
        OP_ROW_START,
        OP_ROW_SET,
        OP_PICK,
        OP_PICK_START,
        OP_PICK_SET,
        OP_FINISH
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic frame_start;
        logic row_start;
        logic no_shrink;
        logic pick_hit;
        logic div_busy;
        logic div_done;
        logic out_free;
    } t_dp_sts;

endpackage

// ----- sv/nds_div.sv -----
// restoring divider, one quotient bit per cycle
`include "nearest_downscale_rgba5551_core_assert.svh"

module nds_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [nds_pkg::PROD_W-1:0]  i_dividend,
    input  logic [nds_pkg::DIM_W-1:0]   i_divisor,
    output logic [nds_pkg::PROD_W-1:0]  o_quotient,
    output logic                        o_busy,
    output logic                        o_done
);

    localparam int PW    = nds_pkg::PROD_W;
    localparam int DW    = nds_pkg::DIM_W;
    localparam int CNT_W = $clog2(PW + 1);

    logic [PW-1:0]    r_quo;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_div;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DW:0]      rem_sh;
    logic [DW:0]      rem_diff;
    logic             take;
    logic [DW-1:0]    n_rem;

    always_comb begin
        rem_sh   = {r_rem, r_quo[PW-1]};
        rem_diff = rem_sh - {1'b0, r_div};
        take     = (rem_sh >= {1'b0, r_div});
        n_rem    = take ? rem_diff[DW-1:0] : rem_sh[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(PW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[PW-2:0], take};
            r_rem <= n_rem;
        end
    end

    assign o_quotient = r_quo;
    assign o_busy     = r_busy;
    assign o_done     = r_done;

    `NDS_ASSERT_IMPL(a_done_after_busy, i_clk, i_rst_n, r_done, $past(r_busy), "divider done without a running division")

endmodule

// ----- sv/nds_datapath.sv -----
// datapath: config, counters, fit, pick tracking, divider and result register
`include "nearest_downscale_rgba5551_core_assert.svh"

module nds_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  nds_pkg::t_dp_cmd                  i_cmd,
    output nds_pkg::t_dp_sts                  o_sts,
    input  logic                              i_cfg_valid,
    input  logic [nds_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [nds_pkg::DIM_W-1:0]         i_cfg_data,
    input  logic [nds_pkg::SAMPLE_W-1:0]      i_sample_first,
    input  logic [nds_pkg::SAMPLE_W-1:0]      i_sample_second,
    input  logic [nds_pkg::SAMPLE_W-1:0]      i_sample_third,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic                              o_pixel_valid,
    output logic [nds_pkg::COORD_W-1:0]       o_out_column,
    output logic [nds_pkg::COORD_W-1:0]       o_out_row,
    output logic [nds_pkg::PIX_W-1:0]         o_pixel_value,
    output logic                              o_frame_done
);

    localparam int DW = nds_pkg::DIM_W;
    localparam int CW = nds_pkg::COORD_W;
    localparam int SW = nds_pkg::SAMPLE_W;
    localparam int PW = nds_pkg::PROD_W;
    localparam int XW = nds_pkg::PIX_W;

    function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] v);
        logic [DW-1:0] res;
        if (v == '0) begin
            res = DW'(1);
        end else if (32'(v) > nds_pkg::MAX_DIM) begin
            res = DW'(nds_pkg::MAX_DIM);
        end else begin
            res = v;
        end
        return res;
    endfunction

    // configuration
    logic [DW-1:0]             r_cfg_sw, r_cfg_sh, r_cfg_bw, r_cfg_bh;
    logic [nds_pkg::CC_W-1:0]  r_cfg_cc;

    // frame state
    logic [DW-1:0] r_col, r_row, r_fit_w, r_fit_h, r_npc, r_nps, r_cur_row;
    logic          r_fit_wide;
    logic          r_hit;
    logic [CW-1:0] r_pick_col, r_pick_row;

    // item and fit payload
    logic [SW-1:0] r_r, r_g, r_b;
    logic [PW-1:0] r_prod_a, r_prod_b;

    // result register
    logic          r_out_valid, r_out_pix_valid, r_out_done;
    logic [CW-1:0] r_out_col, r_out_row;
    logic [XW-1:0] r_out_pixel;

    logic [DW-1:0] sw_c, sh_c, bw_c, bh_c, dw_c, dh_c;
    logic [DW-1:0] mul_x, mul_y;
    logic [PW-1:0] product;
    logic          div_start, div_busy, div_done;
    logic [PW-1:0] div_dividend, div_quo;
    logic [DW-1:0] div_divisor, q_lo, q_fit;
    logic          fit_wide;
    logic [DW:0]   col_inc, row_inc;
    logic          col_wrap, row_wrap, last;
    logic          out_free;
    logic [DW-1:0] n_npc;
    logic [XW-1:0] n_pixel;

    always_comb begin
        sw_c     = clamp_dim(r_cfg_sw);
        sh_c     = clamp_dim(r_cfg_sh);
        bw_c     = clamp_dim(r_cfg_bw);
        bh_c     = clamp_dim(r_cfg_bh);
        dw_c     = (r_fit_w == '0) ? DW'(1) : r_fit_w;
        dh_c     = (r_fit_h == '0) ? DW'(1) : r_fit_h;
        fit_wide = (r_prod_a >= r_prod_b);
        col_inc  = {1'b0, r_col} + (DW + 1)'(1);
        row_inc  = {1'b0, r_row} + (DW + 1)'(1);
        col_wrap = (col_inc >= {1'b0, sw_c});
        row_wrap = (row_inc >= {1'b0, sh_c});
        last     = col_wrap && row_wrap;
        out_free = !r_out_valid || i_out_ready;
        n_npc    = r_npc + DW'(1);
        q_lo     = div_quo[DW-1:0];
        q_fit    = (q_lo == '0) ? DW'(1) : q_lo;
        n_pixel  = (XW'(r_r >> nds_pkg::DROP_BITS) << nds_pkg::RED_LSB)
                 | (XW'(r_g >> nds_pkg::DROP_BITS) << nds_pkg::GREEN_LSB)
                 | (XW'(r_b >> nds_pkg::DROP_BITS) << nds_pkg::BLUE_LSB)
                 | XW'(1);
    end

    // single shared multiplier
    always_comb begin
        mul_x = '0;
        mul_y = '0;
        unique case (i_cmd.op)
            nds_pkg::OP_FIT_MUL_A: begin
                mul_x = sw_c;
                mul_y = bh_c;
            end
            nds_pkg::OP_FIT_MUL_B: begin
                mul_x = sh_c;
                mul_y = bw_c;
            end
            nds_pkg::OP_ROW_START: begin
                mul_x = r_row;
                mul_y = dh_c;
            end
            nds_pkg::OP_PICK_START: begin
                mul_x = r_npc;
                mul_y = sw_c;
            end
            default: begin
            end
        endcase
        product = PW'(mul_x) * PW'(mul_y);
    end

    // divider operands
    always_comb begin
        div_start    = 1'b0;
        div_dividend = product;
        div_divisor  = sh_c;
        unique case (i_cmd.op)
            nds_pkg::OP_FIT_START: begin
                div_start    = 1'b1;
                div_dividend = fit_wide ? r_prod_b : r_prod_a;
                div_divisor  = fit_wide ? sw_c : sh_c;
            end
            nds_pkg::OP_ROW_START: begin
                div_start = 1'b1;
            end
            nds_pkg::OP_PICK_START: begin
                div_start   = 1'b1;
                div_divisor = dw_c;
            end
            default: begin
            end
        endcase
    end

    nds_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_quotient (div_quo),
        .o_busy     (div_busy),
        .o_done     (div_done)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_sw <= DW'(1);
            r_cfg_sh <= DW'(1);
            r_cfg_bw <= DW'(1);
            r_cfg_bh <= DW'(1);
            r_cfg_cc <= nds_pkg::CC_W'(3);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                nds_pkg::CFG_SOURCE_WIDTH:    r_cfg_sw <= i_cfg_data;
                nds_pkg::CFG_SOURCE_HEIGHT:   r_cfg_sh <= i_cfg_data;
                nds_pkg::CFG_BOX_WIDTH:       r_cfg_bw <= i_cfg_data;
                nds_pkg::CFG_BOX_HEIGHT:      r_cfg_bh <= i_cfg_data;
                nds_pkg::CFG_COMPONENT_COUNT: r_cfg_cc <= i_cfg_data[nds_pkg::CC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_fit_w    <= DW'(1);
            r_fit_h    <= DW'(1);
            r_npc      <= '0;
            r_nps      <= '0;
            r_cur_row  <= '0;
            r_fit_wide <= 1'b0;
            r_hit      <= 1'b0;
        end else begin
            unique case (i_cmd.op)
                nds_pkg::OP_FIT_KEEP: begin
                    r_fit_w <= sw_c;
                    r_fit_h <= sh_c;
                end
                nds_pkg::OP_FIT_START: begin
                    r_fit_wide <= fit_wide;
                end
                nds_pkg::OP_FIT_SET: begin
                    if (r_fit_wide) begin
                        r_fit_w <= bw_c;
                        r_fit_h <= q_fit;
                    end else begin
                        r_fit_w <= q_fit;
                        r_fit_h <= bh_c;
                    end
                end
                nds_pkg::OP_ROW_SET: begin
                    r_cur_row <= q_lo;
                    r_npc     <= '0;
                    r_nps     <= '0;
                end
                nds_pkg::OP_PICK: begin
                    r_hit <= o_sts.pick_hit;
                    if (o_sts.pick_hit) begin
                        r_npc <= n_npc;
                    end
                end
                nds_pkg::OP_PICK_SET: begin
                    r_nps <= q_lo;
                end
                nds_pkg::OP_FINISH: begin
                    if (col_wrap) begin
                        r_col <= '0;
                        r_row <= row_wrap ? '0 : row_inc[DW-1:0];
                    end else begin
                        r_col <= col_inc[DW-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // payload captures
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            nds_pkg::OP_ACCEPT: begin
                r_r <= i_sample_first;
                r_g <= (r_cfg_cc >= nds_pkg::CC_W'(2)) ? i_sample_second : i_sample_first;
                r_b <= (r_cfg_cc >= nds_pkg::CC_W'(3)) ? i_sample_third : i_sample_first;
            end
            nds_pkg::OP_FIT_MUL_A: r_prod_a <= product;
            nds_pkg::OP_FIT_MUL_B: r_prod_b <= product;
            nds_pkg::OP_PICK: begin
                r_pick_col <= r_npc[CW-1:0];
                r_pick_row <= r_cur_row[CW-1:0];
            end
            default: begin
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == nds_pkg::OP_FINISH && (r_hit || last)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == nds_pkg::OP_FINISH && (r_hit || last)) begin
            r_out_pix_valid <= r_hit;
            r_out_done      <= last;
            r_out_col       <= r_hit ? r_pick_col : '0;
            r_out_row       <= r_hit ? r_pick_row : '0;
            r_out_pixel     <= r_hit ? n_pixel : '0;
        end
    end

    always_comb begin
        o_sts.frame_start = (r_col == '0) && (r_row == '0);
        o_sts.row_start   = (r_col == '0);
        o_sts.no_shrink   = !((sw_c > bw_c) || (sh_c > bh_c));
        o_sts.pick_hit    = (r_npc < dw_c) && (r_col == r_nps);
        o_sts.div_busy    = div_busy;
        o_sts.div_done    = div_done;
        o_sts.out_free    = out_free;
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_valid = r_out_pix_valid;
    assign o_out_column  = r_out_col;
    assign o_out_row     = r_out_row;
    assign o_pixel_value = r_out_pixel;
    assign o_frame_done  = r_out_done;

    `NDS_ASSERT_IMPL(a_empty_result_is_frame_end, i_clk, i_rst_n, r_out_valid && !r_out_pix_valid, r_out_done && (r_out_pixel == '0) && (r_out_col == '0), "result without a pixel is not a frame end")

endmodule

// ----- sv/nds_ctrl.sv -----
// controller: sequences one source pixel through fit (at frame start), row (at row start), pick and finish
`include "nearest_downscale_rgba5551_core_assert.svh"

module nds_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  nds_pkg::t_dp_sts  i_sts,
    output nds_pkg::t_dp_cmd  o_cmd
);

    nds_pkg::t_state r_state;
    nds_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nds_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            nds_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    priority if (i_sts.frame_start) n_state = nds_pkg::S_FIT_A;
                    else if (i_sts.row_start)       n_state = nds_pkg::S_ROW;
                    else                            n_state = nds_pkg::S_PICK;
                end
            end
            nds_pkg::S_FIT_A:      n_state = nds_pkg::S_FIT_B;
            nds_pkg::S_FIT_B:      n_state = nds_pkg::S_FIT_CHOOSE;
            nds_pkg::S_FIT_CHOOSE: begin
                n_state = i_sts.no_shrink ? nds_pkg::S_ROW : nds_pkg::S_FIT_WAIT;
            end
            nds_pkg::S_FIT_WAIT: begin
                if (i_sts.div_done) n_state = nds_pkg::S_ROW;
            end
            nds_pkg::S_ROW:        n_state = nds_pkg::S_ROW_WAIT;
            nds_pkg::S_ROW_WAIT: begin
                if (i_sts.div_done) n_state = nds_pkg::S_PICK;
            end
            nds_pkg::S_PICK: begin
                n_state = i_sts.pick_hit ? nds_pkg::S_PICK_START : nds_pkg::S_FINISH;
            end
            nds_pkg::S_PICK_START: n_state = nds_pkg::S_PICK_WAIT;
            nds_pkg::S_PICK_WAIT: begin
                if (i_sts.div_done) n_state = nds_pkg::S_FINISH;
            end
            nds_pkg::S_FINISH: begin
                if (i_sts.out_free) n_state = nds_pkg::S_IDLE;
            end
            default: n_state = nds_pkg::S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd.op   = nds_pkg::OP_NONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            nds_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_cmd.op = nds_pkg::OP_ACCEPT;
            end
            nds_pkg::S_FIT_A: o_cmd.op = nds_pkg::OP_FIT_MUL_A;
            nds_pkg::S_FIT_B: o_cmd.op = nds_pkg::OP_FIT_MUL_B;
            nds_pkg::S_FIT_CHOOSE: begin
                o_cmd.op = i_sts.no_shrink ? nds_pkg::OP_FIT_KEEP : nds_pkg::OP_FIT_START;
            end
            nds_pkg::S_FIT_WAIT: begin
                if (i_sts.div_done) o_cmd.op = nds_pkg::OP_FIT_SET;
            end
            nds_pkg::S_ROW: o_cmd.op = nds_pkg::OP_ROW_START;
            nds_pkg::S_ROW_WAIT: begin
                if (i_sts.div_done) o_cmd.op = nds_pkg::OP_ROW_SET;
            end
            nds_pkg::S_PICK:       o_cmd.op = nds_pkg::OP_PICK;
            nds_pkg::S_PICK_START: o_cmd.op = nds_pkg::OP_PICK_START;
            nds_pkg::S_PICK_WAIT: begin
                if (i_sts.div_done) o_cmd.op = nds_pkg::OP_PICK_SET;
            end
            nds_pkg::S_FINISH: begin
                if (i_sts.out_free) o_cmd.op = nds_pkg::OP_FINISH;
            end
            default: begin
            end
        endcase
    end

    `NDS_ASSERT_IMPL(a_idle_divider_quiet, i_clk, i_rst_n, r_state == nds_pkg::S_IDLE, !i_sts.div_busy, "divider running while waiting for a request")
    `NDS_ASSERT_NEXT(a_finish_returns_idle, i_clk, i_rst_n, (r_state == nds_pkg::S_FINISH) && i_sts.out_free, r_state == nds_pkg::S_IDLE, "finish did not release the input side")

endmodule

// ----- sv/nearest_downscale_rgba5551_core.sv -----
// top level of the nearest-neighbour rgba5551 downscaler
//
//  channel   direction   handshake                 carries
//  -------   ---------   -----------------------   -----------------------------------------
//  in        sink        i_in_valid / o_in_ready   one source pixel request, row-major order
//  out       source      o_out_valid / i_out_ready destination pixel write and/or frame end
//  cfg       sink        i_cfg_valid / o_cfg_ready register index and 13-bit write data
//
//  one request is worked at a time; a pixel that is picked adds one pass of the shared
//  restoring divider for the next pick column
//  a request at the start of a source row adds the destination row division, and the
//  first pixel of a frame adds the box fit, whose division is skipped if the source fits
//  the result register frees the input side, so a waiting result only stalls the
//  following request at its finish step
//  synchronous active-low reset; configuration is always ready, with no clearing pass
module nearest_downscale_rgba5551_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // source pixel requests
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [nds_pkg::SAMPLE_W-1:0]     i_sample_first,
    input  logic [nds_pkg::SAMPLE_W-1:0]     i_sample_second,
    input  logic [nds_pkg::SAMPLE_W-1:0]     i_sample_third,
    // results
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_pixel_valid,
    output logic [nds_pkg::COORD_W-1:0]      o_out_column,
    output logic [nds_pkg::COORD_W-1:0]      o_out_row,
    output logic [nds_pkg::PIX_W-1:0]        o_pixel_value,
    output logic                             o_frame_done,
    // register writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [nds_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [nds_pkg::DIM_W-1:0]        i_cfg_data
);

    nds_pkg::t_dp_cmd cmd;
    nds_pkg::t_dp_sts sts;

    // registers are plain flops, a write always lands
    assign o_cfg_ready = 1'b1;

    // sequencer: steps each request through its fit, row and pick phases
    nds_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // counters, fit registers, multiplier, divider and the result register
    nds_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_sample_first  (i_sample_first),
        .i_sample_second (i_sample_second),
        .i_sample_third  (i_sample_third),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_pixel_valid   (o_pixel_valid),
        .o_out_column    (o_out_column),
        .o_out_row       (o_out_row),
        .o_pixel_value   (o_pixel_value),
        .o_frame_done    (o_frame_done)
    );

endmodule
